[hdl/vtk_pkg.sv]
`default_nettype none

package vtk_pkg;

    // Decoder phases.
    localparam logic [1:0] PH_PLAIN   = 2'd0;
    localparam logic [1:0] PH_ESC     = 2'd1;
    localparam logic [1:0] PH_BRACKET = 2'd2;
    localparam logic [1:0] PH_ESC_O   = 2'd3;

    // Request kinds carried in tuser.
    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    localparam int          IDLE_W        = 17;
    localparam logic [16:0] IDLE_MAX      = 17'h1FFFF;
    localparam logic [15:0] TIMEOUT_RESET = 16'd2000;

    // Byte values.
    localparam logic [7:0] KEY_ESC        = 8'd27;
    localparam logic [7:0] KEY_NEWLINE    = 8'd10;
    localparam logic [7:0] KEY_UP_CODE    = 8'd251;
    localparam logic [7:0] KEY_DOWN_CODE  = 8'd252;
    localparam logic [7:0] KEY_LEFT_CODE  = 8'd253;
    localparam logic [7:0] KEY_RIGHT_CODE = 8'd254;
    localparam logic [7:0] CH_BRACKET     = 8'h5B;
    localparam logic [7:0] CH_UPPER_O     = 8'h4F;
    localparam logic [7:0] CH_UPPER_M     = 8'h4D;
    localparam logic [7:0] CH_UPPER_A     = 8'h41;
    localparam logic [7:0] CH_UPPER_B     = 8'h42;
    localparam logic [7:0] CH_UPPER_C     = 8'h43;
    localparam logic [7:0] CH_UPPER_D     = 8'h44;
    localparam logic [7:0] CH_LOWER_J     = 8'h6A;
    localparam logic [7:0] CH_LOWER_Y     = 8'h79;

    // Keypad characters for ESC O j through ESC O y.
    localparam logic [7:0] KEYPAD_MAP [16] = '{
        8'h2A, 8'h2B, 8'h2C, 8'h2D, 8'h2E, 8'h2F, 8'h30, 8'h31,
        8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39
    };

    // Outcome of one request: new state plus an optional key.
    typedef struct packed {
        logic [1:0]        phase;
        logic [IDLE_W-1:0] idle;
        logic              emit;
        logic [7:0]        code;
    } vtk_step_t;

endpackage

`default_nettype wire

[hdl/vtk_decode.sv]
`default_nettype none

module vtk_decode (
    input  wire logic [1:0]  phase,
    input  wire logic [16:0] idle,
    input  wire logic [15:0] timeout,
    input  wire logic        func,
    input  wire logic [7:0]  rx_byte,
    output vtk_pkg::vtk_step_t step
);
    import vtk_pkg::*;

    logic [1:0] start_phase;
    logic [7:0] arrow;
    logic       is_arrow;
    logic [7:0] kp_offset;

    // An open sequence is dropped when the silence exceeds the timeout.
    assign start_phase = (idle > {1'b0, timeout}) ? PH_PLAIN : phase;
    assign kp_offset   = rx_byte - CH_LOWER_J;

    always_comb begin
        is_arrow = 1'b1;
        arrow    = KEY_UP_CODE;
        unique case (rx_byte)
            CH_UPPER_A: arrow = KEY_UP_CODE;
            CH_UPPER_B: arrow = KEY_DOWN_CODE;
            CH_UPPER_C: arrow = KEY_RIGHT_CODE;
            CH_UPPER_D: arrow = KEY_LEFT_CODE;
            default:    is_arrow = 1'b0;
        endcase
    end

    always_comb begin
        step.phase = phase;
        step.idle  = idle;
        step.emit  = 1'b0;
        step.code  = rx_byte;
        if (func == FUNC_TICK) begin
            if (idle != IDLE_MAX) begin
                step.idle = idle + 17'd1;
            end
        end else begin
            step.idle = '0;
            unique case (start_phase)
                PH_PLAIN: begin
                    if (rx_byte == KEY_ESC) begin
                        step.phase = PH_ESC;
                    end else begin
                        step.phase = PH_PLAIN;
                        step.emit  = 1'b1;
                    end
                end
                PH_ESC: begin
                    if (rx_byte == CH_BRACKET) begin
                        step.phase = PH_BRACKET;
                    end else if (rx_byte == CH_UPPER_O) begin
                        step.phase = PH_ESC_O;
                    end else if (rx_byte == KEY_ESC) begin
                        step.phase = PH_ESC;
                        step.emit  = 1'b1;
                        step.code  = KEY_ESC;
                    end else begin
                        step.phase = PH_PLAIN;
                    end
                end
                PH_BRACKET: begin
                    if (rx_byte == CH_UPPER_O) begin
                        step.phase = PH_ESC_O;
                    end else begin
                        step.phase = PH_PLAIN;
                        step.emit  = is_arrow;
                        step.code  = arrow;
                    end
                end
                default: begin
                    step.phase = PH_PLAIN;
                    if (is_arrow) begin
                        step.emit = 1'b1;
                        step.code = arrow;
                    end else if (rx_byte == CH_UPPER_M) begin
                        step.emit = 1'b1;
                        step.code = KEY_NEWLINE;
                    end else if (rx_byte >= CH_LOWER_J && rx_byte <= CH_LOWER_Y) begin
                        step.emit = 1'b1;
                        step.code = KEYPAD_MAP[kp_offset[3:0]];
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[hdl/vt100_key_escape_decoder.sv]
`default_nettype none

// Channel   | Direction | tdata            | tuser         | Notes
// s_        | in        | [7:0] rx_byte    | [0] func      | func 1 is a time tick
// m_        | out       | [7:0] key_code   | -             | zero or one key per request
// cfg_wr_   | in        | [15:0] timeout   | -             | write while idle
//
// Each request is held in the input register and, when it yields a key, moves into
// the result register once that register can take it.
// One request is taken every cycle while the result side keeps up.
// Reset (aresetn low, synchronous) returns the decoder to plain phase, clears the
// idle counter and both valid flags, and sets the timeout to 2000 ticks.
// A stalled result holds the input register, which then stalls s_tready.

module vt100_key_escape_decoder (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic [0:0]  s_tuser,   // [0] func

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] key_code

    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data
);
    import vtk_pkg::*;

    // Input register.
    logic        in_valid_reg;
    logic        in_func_reg;
    logic [7:0]  in_byte_reg;

    // Decoder state and configuration.
    logic [1:0]        phase_reg;
    logic [IDLE_W-1:0] idle_reg;
    logic [15:0]       timeout_reg;

    // Result register.
    logic        out_valid_reg;
    logic [7:0]  out_code_reg;

    logic        advance;
    vtk_step_t   step;

    // The buffered request retires whenever the result register can take it,
    // whether or not it produces a key.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    vtk_decode u_decode (
        .phase   (phase_reg),
        .idle    (idle_reg),
        .timeout (timeout_reg),
        .func    (in_func_reg),
        .rx_byte (in_byte_reg),
        .step    (step)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_func_reg <= s_tuser[0];
            in_byte_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_PLAIN;
            idle_reg  <= '0;
        end else if (advance) begin
            phase_reg <= step.phase;
            idle_reg  <= step.idle;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
        end else if (cfg_wr_en) begin
            timeout_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= step.emit;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && step.emit) begin
            out_code_reg <= step.code;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_code_reg;

endmodule

`default_nettype wire
